### rtl/rtuc_pkg.sv
// ----------------------------------------------------------------------------
// rtuc_pkg
// Shared types and constants for the RTU response checker.
// ----------------------------------------------------------------------------
package rtuc_pkg;

  localparam int unsigned SlaveSlotsDef = 16;
  localparam int unsigned FrameBytesDef = 256;

  localparam logic [7:0]  FailLimitRst   = 8'd3;
  localparam logic [15:0] BackoffRst     = 16'd5000;
  localparam logic [7:0]  DefRetriesRst  = 8'd2;
  localparam logic [7:0]  ExcBit         = 8'h80;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'hA001;

  typedef enum logic [1:0] {
    CMD_JOB     = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_END     = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    V_SENT    = 3'd0,
    V_SKIPPED = 3'd1,
    V_OK      = 3'd2,
    V_EXC     = 3'd3,
    V_RETRY   = 3'd4,
    V_FAILED  = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    REG_FAIL_LIMIT = 2'd0,
    REG_BACKOFF    = 2'd1,
    REG_DEF_RETRY  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input item, reset search
    logic step;       // advance slot search by one entry
    logic decide;     // compute verdict
    logic update;     // write back table / job state
  } ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic search_done;
    logic has_result;
  } sts_t;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/rtuc_if.sv
// ----------------------------------------------------------------------------
// rtuc channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface rtuc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  slave_addr;
  logic [7:0]  function_code;
  logic [15:0] quantity;
  logic [7:0]  retry_limit;
  logic [7:0]  rx_byte;
  logic [31:0] time_ms;
  modport source (output valid, command, slave_addr, function_code, quantity,
                  retry_limit, rx_byte, time_ms, input ready);
  modport sink (input valid, command, slave_addr, function_code, quantity,
                retry_limit, rx_byte, time_ms, output ready);
endinterface

interface rtuc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic [7:0] detail_byte;
  logic [8:0] frame_length;
  logic       slave_online;
  modport source (output valid, verdict, detail_byte, frame_length, slave_online,
                  input ready);
  modport sink (input valid, verdict, detail_byte, frame_length, slave_online,
                output ready);
endinterface

interface rtuc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/rtu_response_checker.sv
// ----------------------------------------------------------------------------
// rtu_response_checker
// Modbus RTU master response checker, top level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transfer: new job, response byte, frame
//   end or response timeout. out_ch carries zero or one verdict per command.
//   cfg_ch writes fail_limit (0), backoff_ms (1), default_retries (2);
//   writes are taken at any time and should only be issued while idle.
// Timing:
//   One item at a time. An item passes capture, slot search, decide and
//   write back before the result is registered; the search scans one
//   slave table entry per step (up to SlaveSlots); bytes skip the scan.
//   in_ch.ready is low from acceptance to write back, or to result taken.
// Reset:
//   Clears the job, frame, CRC and slot count; registers return to
//   3 / 5000 / 2. Slot entries are written on creation before any read.
// Stall:
//   A result waits on out_ch with valid high until ready; no item is
//   accepted meanwhile.
// ----------------------------------------------------------------------------
module rtu_response_checker import rtuc_pkg::*; #(
  parameter int unsigned SlaveSlots = SlaveSlotsDef,
  parameter int unsigned FrameBytes = FrameBytesDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  rtuc_in_if.sink     in_ch,
  rtuc_out_if.source  out_ch,
  rtuc_cfg_if.sink    cfg_ch
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  rtuc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  rtuc_dp #(
    .SlaveSlots (SlaveSlots),
    .FrameBytes (FrameBytes)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .command_i       (in_ch.command),
    .slave_addr_i    (in_ch.slave_addr),
    .function_code_i (in_ch.function_code),
    .quantity_i      (in_ch.quantity),
    .retry_limit_i   (in_ch.retry_limit),
    .rx_byte_i       (in_ch.rx_byte),
    .time_ms_i       (in_ch.time_ms),
    .cfg_we_i        (cfg_ch.valid),
    .cfg_index_i     (cfg_ch.index),
    .cfg_data_i      (cfg_ch.data),
    .verdict_o       (out_ch.verdict),
    .detail_byte_o   (out_ch.detail_byte),
    .frame_length_o  (out_ch.frame_length),
    .slave_online_o  (out_ch.slave_online)
  );

endmodule

### rtl/rtuc_ctrl.sv
// ----------------------------------------------------------------------------
// rtuc_ctrl
// Sequencer: capture, slot search, decide, write back, present result.
// ----------------------------------------------------------------------------
module rtuc_ctrl import rtuc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output ctl_t ctl_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SEARCH;
      ST_SEARCH: if (sts_i.search_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_UPDATE;
      ST_UPDATE: state_d = sts_i.has_result ? ST_OUT : ST_IDLE;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      ST_SEARCH: ctl_o.step = 1'b1;
      ST_DECIDE: ctl_o.decide = 1'b1;
      ST_UPDATE: ctl_o.update = 1'b1;
      ST_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  a_update_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.update |=> !ctl_o.update) else $error("double write back");

endmodule

### rtl/rtuc_dp.sv
// ----------------------------------------------------------------------------
// rtuc_dp
// Datapath: job state, frame checks, CRC, slave table, result register.
// ----------------------------------------------------------------------------
module rtuc_dp import rtuc_pkg::*; #(
  parameter int unsigned SlaveSlots = SlaveSlotsDef,
  parameter int unsigned FrameBytes = FrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  slave_addr_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] quantity_i,
  input  logic [7:0]  retry_limit_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] time_ms_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic [2:0]  verdict_o,
  output logic [7:0]  detail_byte_o,
  output logic [8:0]  frame_length_o,
  output logic        slave_online_o
);

  localparam int unsigned SW = (SlaveSlots > 1) ? $clog2(SlaveSlots) : 1;
  localparam int unsigned CW = $clog2(SlaveSlots + 1);
  localparam int unsigned LW = $clog2(FrameBytes + 1);

  // configuration
  logic [7:0]  fail_limit_q, def_retries_q;
  logic [15:0] backoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_limit_q  <= FailLimitRst;
      backoff_q     <= BackoffRst;
      def_retries_q <= DefRetriesRst;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_FAIL_LIMIT: fail_limit_q  <= cfg_data_i[7:0];
        REG_BACKOFF:    backoff_q     <= cfg_data_i;
        REG_DEF_RETRY:  def_retries_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]  cmd_q;
  logic [7:0]  addr_q, fn_q, lim_q, byte_q;
  logic [15:0] qty_q;
  logic [31:0] now_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= command_i;
      addr_q <= slave_addr_i;
      fn_q   <= function_code_i;
      qty_q  <= quantity_i;
      lim_q  <= retry_limit_i;
      byte_q <= rx_byte_i;
      now_q  <= time_ms_i;
    end
  end

  // job and frame state
  logic        job_active_q;
  logic [7:0]  job_slave_q, job_fn_q, job_lim_q, retries_q;
  logic [15:0] job_qty_q, crc_q;
  logic [LW-1:0] held_q;
  logic [7:0]  head_q [3];
  logic [CW-1:0] slot_count_q;

  // slave table (flops, read at the search, hit and write-back slot indices)
  logic [7:0]  slot_slave_q [SlaveSlots];
  logic [7:0]  slot_fails_q [SlaveSlots];
  logic        slot_online_q [SlaveSlots];
  logic [31:0] slot_time_q [SlaveSlots];

  // search
  logic [CW-1:0] idx_q;
  logic          found_q;
  logic [SW-1:0] hit_q;
  logic [7:0]    key;
  logic          at_end;

  assign key    = (cmd_q == CMD_JOB) ? addr_q : job_slave_q;
  assign at_end = (idx_q >= slot_count_q);
  assign sts_o.search_done = found_q || at_end || (cmd_q == CMD_BYTE);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (ctl_i.step && !sts_o.search_done) begin
      if (slot_slave_q[idx_q[SW-1:0]] == key) begin
        found_q <= 1'b1;
        hit_q   <= idx_q[SW-1:0];
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // decision
  logic [2:0]  v_q;
  logic        res_q, slot_ok_q, newslot_q;
  logic [SW-1:0] slot_q;
  logic [16:0] expect_w;
  logic [8:0]  len9;
  logic        chk_ok, chk_exc;
  logic        online_cur;

  assign len9 = 9'(held_q);

  always_comb begin
    expect_w = '0;
    chk_ok   = 1'b0;
    chk_exc  = 1'b0;
    if (len9 >= 9'd5 && crc_q == 16'h0000 && head_q[0] == job_slave_q) begin
      if ((head_q[1] & ExcBit) != 8'h00) begin
        chk_exc = 1'b1;
      end else if (head_q[1] == job_fn_q) begin
        case (job_fn_q)
          8'h01, 8'h02: begin
            expect_w = 17'(({1'b0, job_qty_q} + 17'd7) >> 3);
            chk_ok = (17'(head_q[2]) == expect_w) && (len9 == 9'(head_q[2]) + 9'd5);
          end
          8'h03, 8'h04: begin
            expect_w = {job_qty_q, 1'b0};
            chk_ok = (17'(head_q[2]) == expect_w) && (len9 == 9'(head_q[2]) + 9'd5);
          end
          8'h05, 8'h06, 8'h0F, 8'h10: chk_ok = (len9 == 9'd8);
          default: chk_ok = 1'b0;
        endcase
      end
    end
  end

  assign online_cur = slot_online_q[hit_q];

  always_ff @(posedge clk_i) begin
    if (ctl_i.decide) begin
      newslot_q <= 1'b0;
      slot_ok_q <= found_q;
      slot_q    <= hit_q;
      res_q     <= 1'b0;
      v_q       <= V_SENT;
      case (cmd_e'(cmd_q))
        CMD_JOB: begin
          res_q <= 1'b1;
          if (!found_q && slot_count_q < CW'(SlaveSlots)) begin
            newslot_q <= 1'b1;
            slot_ok_q <= 1'b1;
            slot_q    <= slot_count_q[SW-1:0];
          end
          if (found_q && !online_cur && now_q < slot_time_q[hit_q]) begin
            v_q <= V_SKIPPED;
          end
        end
        CMD_BYTE: ;
        CMD_END, CMD_TIMEOUT: begin
          res_q <= job_active_q && !(cmd_q == CMD_END && held_q == '0);
          if (chk_ok) v_q <= V_OK;
          else if (chk_exc) v_q <= V_EXC;
          else if (retries_q < job_lim_q) v_q <= V_RETRY;
          else v_q <= V_FAILED;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.has_result = res_q;

  // write back
  logic [7:0] fails_inc;
  logic       on_new;
  assign fails_inc = (slot_fails_q[slot_q] == 8'hFF) ? 8'hFF : slot_fails_q[slot_q] + 8'd1;

  always_comb begin
    on_new = 1'b1;
    if (slot_ok_q) begin
      on_new = newslot_q ? 1'b1 : slot_online_q[slot_q];
      if (cmd_q != CMD_JOB) begin
        if (v_q == V_OK) on_new = 1'b1;
        else if (v_q == V_FAILED && fails_inc >= fail_limit_q) on_new = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.update && slot_ok_q) begin
      if (newslot_q) begin
        slot_slave_q[slot_q]  <= addr_q;
        slot_fails_q[slot_q]  <= '0;
        slot_online_q[slot_q] <= 1'b1;
        slot_time_q[slot_q]   <= '0;
      end else if (cmd_q != CMD_JOB && res_q) begin
        if (v_q == V_OK) begin
          slot_fails_q[slot_q]  <= '0;
          slot_online_q[slot_q] <= 1'b1;
        end else if (v_q == V_FAILED) begin
          slot_fails_q[slot_q] <= fails_inc;
          if (fails_inc >= fail_limit_q) begin
            slot_online_q[slot_q] <= 1'b0;
            slot_time_q[slot_q]   <= now_q + {16'h0000, backoff_q};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.update && res_q) begin
      verdict_o      <= v_q;
      slave_online_o <= on_new;
      if (cmd_q == CMD_JOB) begin
        detail_byte_o  <= '0;
        frame_length_o <= '0;
      end else begin
        detail_byte_o  <= head_q[2];
        frame_length_o <= len9;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_active_q <= 1'b0;
      job_slave_q  <= '0;
      job_fn_q     <= '0;
      job_qty_q    <= '0;
      job_lim_q    <= '0;
      retries_q    <= '0;
      held_q       <= '0;
      crc_q        <= CrcInit;
      head_q       <= '{default: '0};
      slot_count_q <= '0;
    end else if (ctl_i.update) begin
      case (cmd_e'(cmd_q))
        CMD_JOB: begin
          if (newslot_q) slot_count_q <= slot_count_q + 1'b1;
          retries_q <= '0;
          held_q    <= '0;
          crc_q     <= CrcInit;
          head_q    <= '{default: '0};
          job_active_q <= (v_q != V_SKIPPED);
          if (v_q != V_SKIPPED) begin
            job_slave_q <= addr_q;
            job_fn_q    <= fn_q;
            job_qty_q   <= qty_q;
            job_lim_q   <= (lim_q != 8'h00) ? lim_q : def_retries_q;
          end
        end
        CMD_BYTE: begin
          if (job_active_q && held_q < LW'(FrameBytes)) begin
            if (held_q < LW'(3)) head_q[held_q[1:0]] <= byte_q;
            crc_q  <= crc_fold(crc_q, byte_q);
            held_q <= held_q + 1'b1;
          end
        end
        default: begin
          if (res_q) begin
            held_q <= '0;
            crc_q  <= CrcInit;
            head_q <= '{default: '0};
            if (v_q == V_RETRY) begin
              retries_q <= retries_q + 8'd1;
            end else begin
              retries_q    <= '0;
              job_active_q <= 1'b0;
            end
          end
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_count_q <= CW'(SlaveSlots)) else $error("slot count overflow");
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= LW'(FrameBytes)) else $error("frame length overflow");
  a_idle_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_active_q |-> held_q == '0) else $error("bytes held without job");

endmodule
